FILE: hw/rtl/motor_homing_sequencer_defines.svh
// Assertion macros for the motor homing sequencer RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MOTOR_HOMING_SEQUENCER_DEFINES_SVH
`define MOTOR_HOMING_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MHS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MHS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mhs_pkg.sv
// Package for the motor homing sequencer: widths, codes, register map,
// configuration struct and controller/datapath command and status types.
`default_nettype none

package mhs_pkg;

   localparam int DataWidth = 32;
   localparam int TolWidth  = 31;
   localparam int WideWidth = DataWidth + 1;   // difference of two data words
   localparam int AddrWidth = 5;

   typedef enum logic [2:0] {
      REG_HOMING_VELOCITY = 3'd0,
      REG_MIN_POSITION    = 3'd1,
      REG_MAX_POSITION    = 3'd2,
      REG_ZERO_OFFSET     = 3'd3,
      REG_MOTION_LOW      = 3'd4,
      REG_MOTION_HIGH     = 3'd5,
      REG_MOTION_START    = 3'd6,
      REG_TOLERANCE       = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_SEEK   = 2'd1,
      PH_MOVE   = 2'd2,
      PH_SETTLE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      DRV_NONE     = 2'd0,
      DRV_VELOCITY = 2'd1,
      DRV_POSITION = 2'd2
   } drive_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SIGN,
      ST_DIVIDE,
      ST_MAP,
      ST_CHECK,
      ST_COMMIT
   } ctl_state_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] homing_velocity;
      logic signed [DataWidth-1:0] min_position;
      logic signed [DataWidth-1:0] max_position;
      logic signed [DataWidth-1:0] zero_offset;
      logic signed [DataWidth-1:0] motion_low;
      logic signed [DataWidth-1:0] motion_high;
      logic signed [DataWidth-1:0] motion_start;
      logic [TolWidth-1:0]         tolerance;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic div_start;
      logic map;
      logic check;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic need_target;
      logic div_done;
   } ctl_status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/motor_homing_sequencer.sv
// Top level of the motor homing sequencer: configuration registers,
// controller and datapath. Depends on mhs_pkg, mhs_csr, mhs_ctrl, mhs_datapath.
`default_nettype none

// Steps a motor homing sequence once per accepted item (one control tick) and
// returns exactly one result item per input item. Items that restart the
// sequence, arrive while it is inactive, or fall in the start or seek-minimum
// phases skip the target computation and go from preparation straight to commit.
// Items in the move and settle phases compute the position target, min_position
// plus (clamped motion_start - motion_low) * (max_position - min_position) /
// (motion_high - motion_low), in a multiply-divide unit that retires one
// quotient bit per cycle over 33 bits. A new item is accepted while the previous
// result still waits on the result channel. Values are signed Q16.16; the mapping
// is a ratio, so the arithmetic does not depend on the binary point. Configuration
// registers sit at byte address 4*index and must be written only while the
// block is idle.
module motor_homing_sequencer
   import mhs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_restart,
   input  logic                        req_stalled,
   input  logic signed [DataWidth-1:0] req_measured_position,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_drive_mode,
   output logic signed [DataWidth-1:0] rsp_drive_value,
   output logic                        rsp_rezero,
   output logic signed [DataWidth-1:0] rsp_rezero_value,
   output logic                        rsp_gains_select,
   output logic [1:0]                  rsp_phase,
   output logic                        rsp_busy_res,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [AddrWidth-1:0]        paddr,
   input  logic [DataWidth-1:0]        pwdata,
   output logic [DataWidth-1:0]        prdata,
   output logic                        pready
);

   cfg_type        cfg;
   ctl_cmd_type    cmd;
   ctl_status_type status;

   mhs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mhs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   mhs_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .cfg                   (cfg),
      .req_restart           (req_restart),
      .req_stalled           (req_stalled),
      .req_measured_position (req_measured_position),
      .rsp_drive_mode        (rsp_drive_mode),
      .rsp_drive_value       (rsp_drive_value),
      .rsp_rezero            (rsp_rezero),
      .rsp_rezero_value      (rsp_rezero_value),
      .rsp_gains_select      (rsp_gains_select),
      .rsp_phase             (rsp_phase),
      .rsp_busy_res          (rsp_busy_res)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/mhs_csr.sv
// Configuration register file of the motor homing sequencer, APB-style port.
// Depends on mhs_pkg for the register map and the configuration struct.
`default_nettype none

module mhs_csr
   import mhs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [AddrWidth-1:0] paddr,
   input  logic [DataWidth-1:0] pwdata,
   output logic [DataWidth-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type       cfg_ff, cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign wr_en  = psel && penable && pwrite;
   assign idx    = reg_index_type'(paddr[AddrWidth-1:2]);
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_HOMING_VELOCITY: cfg_in.homing_velocity = pwdata;
            REG_MIN_POSITION:    cfg_in.min_position    = pwdata;
            REG_MAX_POSITION:    cfg_in.max_position    = pwdata;
            REG_ZERO_OFFSET:     cfg_in.zero_offset     = pwdata;
            REG_MOTION_LOW:      cfg_in.motion_low      = pwdata;
            REG_MOTION_HIGH:     cfg_in.motion_high     = pwdata;
            REG_MOTION_START:    cfg_in.motion_start    = pwdata;
            REG_TOLERANCE:       cfg_in.tolerance       = pwdata[TolWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_HOMING_VELOCITY: prdata = cfg_ff.homing_velocity;
         REG_MIN_POSITION:    prdata = cfg_ff.min_position;
         REG_MAX_POSITION:    prdata = cfg_ff.max_position;
         REG_ZERO_OFFSET:     prdata = cfg_ff.zero_offset;
         REG_MOTION_LOW:      prdata = cfg_ff.motion_low;
         REG_MOTION_HIGH:     prdata = cfg_ff.motion_high;
         REG_MOTION_START:    prdata = cfg_ff.motion_start;
         REG_TOLERANCE:       prdata = {{(DataWidth-TolWidth){1'b0}}, cfg_ff.tolerance};
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mhs_muldiv.sv
// Iterative unit for floor(a*b/c) with a <= c: one bit of b per cycle,
// shift-add into the remainder and subtract c up to twice. Uses mhs_pkg widths.
`default_nettype none

module mhs_muldiv
   import mhs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WideWidth-1:0] mul_a,
   input  logic [WideWidth-1:0] mul_b,
   input  logic [WideWidth-1:0] div_c,
   output logic [WideWidth-1:0] quotient,
   output logic                 done
);

   localparam int CntWidth = $clog2(WideWidth);
   localparam int RemWidth = WideWidth + 2;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic [WideWidth-1:0] a_ff, a_in;
   logic [WideWidth-1:0] b_ff, b_in;
   logic [WideWidth-1:0] c_ff, c_in;
   logic [WideWidth-1:0] r_ff, r_in;
   logic [WideWidth-1:0] q_ff, q_in;
   logic [RemWidth-1:0]  r2;
   logic [RemWidth:0]    s1, s2;
   logic [1:0]           digit;

   assign quotient = q_ff;
   assign done     = done_ff;

   always_comb begin
      r2 = {1'b0, r_ff, 1'b0} + (b_ff[WideWidth-1] ? {2'b00, a_ff} : {RemWidth{1'b0}});
      s1 = {1'b0, r2} - {3'b000, c_ff};
      s2 = {1'b0, r2} - {2'b00, c_ff, 1'b0};
      if (!s2[RemWidth]) begin
         digit = 2'd2;
      end else if (!s1[RemWidth]) begin
         digit = 2'd1;
      end else begin
         digit = 2'd0;
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntWidth'(WideWidth - 1);
         a_in    = mul_a;
         b_in    = mul_b;
         c_in    = div_c;
         r_in    = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         b_in = {b_ff[WideWidth-2:0], 1'b0};
         q_in = {q_ff[WideWidth-2:0], 1'b0} + {{(WideWidth-2){1'b0}}, digit};
         case (digit)
            2'd2:    r_in = s2[WideWidth-1:0];
            2'd1:    r_in = s1[WideWidth-1:0];
            default: r_in = r2[WideWidth-1:0];
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      r_ff   <= r_in;
      q_ff   <= q_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mhs_datapath.sv
// Datapath of the motor homing sequencer: item capture, target mapping,
// homing sequence state and result registers. Depends on mhs_pkg, mhs_muldiv.
`default_nettype none

module mhs_datapath
   import mhs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  ctl_cmd_type                 cmd,
   output ctl_status_type              status,
   input  cfg_type                     cfg,
   input  logic                        req_restart,
   input  logic                        req_stalled,
   input  logic signed [DataWidth-1:0] req_measured_position,
   output logic [1:0]                  rsp_drive_mode,
   output logic signed [DataWidth-1:0] rsp_drive_value,
   output logic                        rsp_rezero,
   output logic signed [DataWidth-1:0] rsp_rezero_value,
   output logic                        rsp_gains_select,
   output logic [1:0]                  rsp_phase,
   output logic                        rsp_busy_res
);

   localparam int TargetWidth = DataWidth + 2;

   // captured item
   logic                        restart_ff, restart_in;
   logic                        stalled_ff, stalled_in;
   logic signed [DataWidth-1:0] pos_ff, pos_in;

   // target mapping
   logic signed [WideWidth-1:0]   num_ff, num_in;
   logic signed [WideWidth-1:0]   den_ff, den_in;
   logic signed [WideWidth-1:0]   span_ff, span_in;
   logic                          neg_ff, neg_in;
   logic                          den_zero_ff, den_zero_in;
   logic signed [TargetWidth-1:0] traw_ff, traw_in;
   logic signed [DataWidth-1:0]   target_ff, target_in;
   logic signed [WideWidth-1:0]   err_ff, err_in;

   // homing sequence state
   phase_type phase_ff, phase_in;
   logic      active_ff, active_in;
   logic      min_reached_ff, min_reached_in;
   logic      gains_ff, gains_in;

   // result registers
   drive_mode_type              mode_ff, mode_in;
   logic signed [DataWidth-1:0] value_ff, value_in;
   logic                        rezero_ff, rezero_in;
   logic signed [DataWidth-1:0] rezero_value_ff, rezero_value_in;

   // combinational helpers
   logic signed [DataWidth-1:0]   m_low, m_high, m_start, m_clamp;
   logic signed [DataWidth-1:0]   p_min, p_max, t_clamp;
   logic signed [TargetWidth-1:0] min_ext, max_ext, q_signed;
   logic [WideWidth-1:0]          abs_num, abs_span, abs_den, quotient;
   logic signed [WideWidth-1:0]   tol_pos, tol_neg, rz_sum;
   logic                          in_band, div_done;

   mhs_muldiv u_muldiv (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .mul_a    (abs_num),
      .mul_b    (abs_span),
      .div_c    (abs_den),
      .quotient (quotient),
      .done     (div_done)
   );

   assign status.need_target = !restart_ff && active_ff
                               && ((phase_ff == PH_MOVE) || (phase_ff == PH_SETTLE));
   assign status.div_done    = div_done;

   assign m_low   = cfg.motion_low;
   assign m_high  = cfg.motion_high;
   assign m_start = cfg.motion_start;
   assign p_min   = cfg.min_position;
   assign p_max   = cfg.max_position;
   assign min_ext = {{2{p_min[DataWidth-1]}}, p_min};
   assign max_ext = {{2{p_max[DataWidth-1]}}, p_max};

   // item capture and the mapping pipeline
   always_comb begin
      restart_in = restart_ff;
      stalled_in = stalled_ff;
      pos_in     = pos_ff;
      if (cmd.load) begin
         restart_in = req_restart;
         stalled_in = req_stalled;
         pos_in     = req_measured_position;
      end

      // below low gives low, else above high gives high
      if (m_start < m_low) begin
         m_clamp = m_low;
      end else if (m_start > m_high) begin
         m_clamp = m_high;
      end else begin
         m_clamp = m_start;
      end
      num_in  = num_ff;
      den_in  = den_ff;
      span_in = span_ff;
      if (cmd.prep) begin
         num_in  = {m_clamp[DataWidth-1], m_clamp} - {m_low[DataWidth-1], m_low};
         den_in  = {m_high[DataWidth-1], m_high} - {m_low[DataWidth-1], m_low};
         span_in = {p_max[DataWidth-1], p_max} - {p_min[DataWidth-1], p_min};
      end

      abs_num  = num_ff[WideWidth-1]  ? ({WideWidth{1'b0}} - num_ff)  : num_ff;
      abs_span = span_ff[WideWidth-1] ? ({WideWidth{1'b0}} - span_ff) : span_ff;
      abs_den  = den_ff[WideWidth-1]  ? ({WideWidth{1'b0}} - den_ff)  : den_ff;
      neg_in      = neg_ff;
      den_zero_in = den_zero_ff;
      if (cmd.div_start) begin
         neg_in      = num_ff[WideWidth-1] ^ den_ff[WideWidth-1] ^ span_ff[WideWidth-1];
         den_zero_in = (den_ff == '0);
      end

      q_signed = neg_ff ? ({TargetWidth{1'b0}} - {1'b0, quotient}) : {1'b0, quotient};
      traw_in  = traw_ff;
      if (cmd.map) begin
         traw_in = den_zero_ff ? min_ext : (min_ext + q_signed);
      end

      if (traw_ff < min_ext) begin
         t_clamp = p_min;
      end else if (traw_ff > max_ext) begin
         t_clamp = p_max;
      end else begin
         t_clamp = traw_ff[DataWidth-1:0];
      end
      target_in = target_ff;
      err_in    = err_ff;
      if (cmd.check) begin
         target_in = t_clamp;
         err_in    = {pos_ff[DataWidth-1], pos_ff} - {t_clamp[DataWidth-1], t_clamp};
      end
   end

   // one step of the homing sequence
   always_comb begin
      tol_pos = {{(WideWidth-TolWidth){1'b0}}, cfg.tolerance};
      tol_neg = {WideWidth{1'b0}} - tol_pos;
      in_band = (err_ff < tol_pos) && (err_ff > tol_neg);
      rz_sum  = {p_min[DataWidth-1], p_min}
                + {cfg.zero_offset[DataWidth-1], cfg.zero_offset};

      phase_in        = phase_ff;
      active_in       = active_ff;
      min_reached_in  = min_reached_ff;
      gains_in        = gains_ff;
      mode_in         = DRV_NONE;
      value_in        = '0;
      rezero_in       = 1'b0;
      rezero_value_in = '0;

      if (restart_ff) begin
         phase_in       = PH_START;
         active_in      = 1'b1;
         min_reached_in = 1'b0;
      end else if (active_ff) begin
         unique case (phase_ff)
            PH_START: begin
               gains_in = 1'b1;
               phase_in = PH_SEEK;
            end
            PH_SEEK: begin
               if (min_reached_ff) begin
                  phase_in       = PH_MOVE;
                  min_reached_in = 1'b0;
               end else if (stalled_ff) begin
                  rezero_in = 1'b1;
                  // saturate min plus offset
                  if (rz_sum[WideWidth-1] != rz_sum[DataWidth-1]) begin
                     rezero_value_in = rz_sum[WideWidth-1]
                                       ? {1'b1, {(DataWidth-1){1'b0}}}
                                       : {1'b0, {(DataWidth-1){1'b1}}};
                  end else begin
                     rezero_value_in = rz_sum[DataWidth-1:0];
                  end
                  mode_in        = DRV_VELOCITY;
                  min_reached_in = 1'b1;
               end else begin
                  mode_in  = DRV_VELOCITY;
                  value_in = cfg.homing_velocity;
               end
            end
            PH_MOVE: begin
               mode_in  = DRV_POSITION;
               value_in = target_ff;
               if (in_band) begin
                  phase_in = PH_SETTLE;
               end
            end
            PH_SETTLE: begin
               if (in_band) begin
                  phase_in  = PH_START;
                  active_in = 1'b0;
                  gains_in  = 1'b0;
               end else begin
                  mode_in  = DRV_POSITION;
                  value_in = target_ff;
               end
            end
            default: phase_in = PH_START;
         endcase
      end
   end

   assign rsp_drive_mode   = mode_ff;
   assign rsp_drive_value  = value_ff;
   assign rsp_rezero       = rezero_ff;
   assign rsp_rezero_value = rezero_value_ff;
   assign rsp_gains_select = gains_ff;
   assign rsp_phase        = phase_ff;
   assign rsp_busy_res     = active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         active_ff      <= 1'b1;
         min_reached_ff <= 1'b0;
         gains_ff       <= 1'b0;
      end else if (cmd.commit) begin
         phase_ff       <= phase_in;
         active_ff      <= active_in;
         min_reached_ff <= min_reached_in;
         gains_ff       <= gains_in;
      end
      if (cmd.commit) begin
         mode_ff         <= mode_in;
         value_ff        <= value_in;
         rezero_ff       <= rezero_in;
         rezero_value_ff <= rezero_value_in;
      end
      restart_ff  <= restart_in;
      stalled_ff  <= stalled_in;
      pos_ff      <= pos_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      span_ff     <= span_in;
      neg_ff      <= neg_in;
      den_zero_ff <= den_zero_in;
      traw_ff     <= traw_in;
      target_ff   <= target_in;
      err_ff      <= err_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/mhs_ctrl.sv
// Controller of the motor homing sequencer: handshakes and step sequencing.
// Depends on mhs_pkg and the assertion macros in the defines header.
`default_nettype none
`include "motor_homing_sequencer_defines.svh"

module mhs_ctrl
   import mhs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output ctl_cmd_type    cmd,
   input  ctl_status_type status
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_PREP;
         ST_PREP:   state_in = status.need_target ? ST_SIGN : ST_COMMIT;
         ST_SIGN:   state_in = ST_DIVIDE;
         ST_DIVIDE: if (status.div_done) state_in = ST_MAP;
         ST_MAP:    state_in = ST_CHECK;
         ST_CHECK:  state_in = ST_COMMIT;
         ST_COMMIT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      cmd.load      = req_valid && (state_ff == ST_IDLE);
      cmd.prep      = (state_ff == ST_PREP);
      cmd.div_start = (state_ff == ST_SIGN);
      cmd.map       = (state_ff == ST_MAP);
      cmd.check     = (state_ff == ST_CHECK);
      cmd.commit    = (state_ff == ST_COMMIT) && out_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MHS_ASSERT_IMPL(a_commit_room, clock, reset, cmd.commit, !rsp_valid_ff || rsp_ready, "result register overwritten before taken")
   `MHS_ASSERT_IMPL(a_done_in_divide, clock, reset, status.div_done, state_ff == ST_DIVIDE, "divider finished outside the divide state")
   `MHS_ASSERT_NEXT(a_accept_prep, clock, reset, req_valid && req_ready, state_ff == ST_PREP, "accepted item did not start preparation")
   `MHS_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid_ff && state_ff == ST_IDLE, "committed result not presented")

endmodule

`default_nettype wire

FILE: verif/homing_checker.sv
// Scoreboard for the motor homing sequencer: follows register writes, predicts
// one result item per accepted tick and compares results in order. Uses mhs_pkg.
module homing_checker
   import mhs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_restart,
   input  logic                        req_stalled,
   input  logic signed [DataWidth-1:0] req_measured_position,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [1:0]                  rsp_drive_mode,
   input  logic signed [DataWidth-1:0] rsp_drive_value,
   input  logic                        rsp_rezero,
   input  logic signed [DataWidth-1:0] rsp_rezero_value,
   input  logic                        rsp_gains_select,
   input  logic [1:0]                  rsp_phase,
   input  logic                        rsp_busy_res,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic                        pready,
   input  logic [AddrWidth-1:0]        paddr,
   input  logic [DataWidth-1:0]        pwdata,
   output int                          mismatches,
   output int                          outstanding,
   output int                          results_seen,
   output int                          homings_done,
   output logic signed [DataWidth-1:0] target_now
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      drive_mode_type              mode;
      logic signed [DataWidth-1:0] value;
      logic                        rezero;
      logic signed [DataWidth-1:0] rezero_value;
      logic                        gains;
      phase_type                   phase;
      logic                        busy;
   } tick_result_type;

   localparam longint Int32Min = -(longint'(1) <<< 31);
   localparam longint Int32Max = (longint'(1) <<< 31) - 1;

   tick_result_type commands_due[$];
   cfg_type         cfg;
   phase_type       seq_phase;
   logic            seq_active;
   logic            seq_at_min;
   logic            seq_gains;

   function automatic longint clamp_range(longint x, longint lo, longint hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x;
   endfunction

   // Map clamped motion_start onto [min_position, max_position], truncating toward zero.
   function automatic longint homing_target(cfg_type c);
      longint     lo, hi, m, num, den, pmin, pmax, span, q, t;
      logic [67:0] a_mag, b_mag, c_mag;
      bit         neg;
      lo   = $signed(c.motion_low);
      hi   = $signed(c.motion_high);
      pmin = $signed(c.min_position);
      pmax = $signed(c.max_position);
      m    = clamp_range($signed(c.motion_start), lo, hi);
      num  = m - lo;
      den  = hi - lo;
      span = pmax - pmin;
      if (den == 0) begin
         t = pmin;
      end else begin
         neg   = ((num < 0) != (den < 0)) != (span < 0);
         a_mag = (num < 0) ? -num : num;
         b_mag = (span < 0) ? -span : span;
         c_mag = (den < 0) ? -den : den;
         q     = longint'((a_mag * b_mag) / c_mag);
         t     = neg ? pmin - q : pmin + q;
      end
      return clamp_range(t, pmin, pmax);
   endfunction

   assign target_now = DataWidth'(homing_target(cfg));

   task automatic check_field(input string name, input logic [DataWidth-1:0] want,
                              input logic [DataWidth-1:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : track
      tick_result_type want;
      longint          pos, target, err;
      bit              near;
      if (reset) begin
         cfg          = '0;
         seq_phase    = PH_START;
         seq_active   = 1'b1;
         seq_at_min   = 1'b0;
         seq_gains    = 1'b0;
         commands_due.delete();
         mismatches   = 0;
         results_seen = 0;
         homings_done = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[AddrWidth-1:2]))
               REG_HOMING_VELOCITY: cfg.homing_velocity = pwdata;
               REG_MIN_POSITION:    cfg.min_position    = pwdata;
               REG_MAX_POSITION:    cfg.max_position    = pwdata;
               REG_ZERO_OFFSET:     cfg.zero_offset     = pwdata;
               REG_MOTION_LOW:      cfg.motion_low      = pwdata;
               REG_MOTION_HIGH:     cfg.motion_high     = pwdata;
               REG_MOTION_START:    cfg.motion_start    = pwdata;
               REG_TOLERANCE:       cfg.tolerance       = pwdata[TolWidth-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            want.mode         = DRV_NONE;
            want.value        = '0;
            want.rezero       = 1'b0;
            want.rezero_value = '0;
            pos    = req_measured_position;
            target = homing_target(cfg);
            err    = pos - target;
            if (err < 0) err = -err;
            near   = err < longint'(cfg.tolerance);
            if (req_restart) begin
               seq_phase  = PH_START;
               seq_active = 1'b1;
               seq_at_min = 1'b0;
            end else if (seq_active) begin
               case (seq_phase)
                  PH_START: begin
                     seq_gains = 1'b1;
                     seq_phase = PH_SEEK;
                  end
                  PH_SEEK: begin
                     if (seq_at_min) begin
                        seq_phase  = PH_MOVE;
                        seq_at_min = 1'b0;
                     end else if (req_stalled) begin
                        // hit the end stop: re-zero there and hold still
                        want.rezero       = 1'b1;
                        want.rezero_value = DataWidth'(clamp_range(
                           longint'($signed(cfg.min_position)) +
                           longint'($signed(cfg.zero_offset)), Int32Min, Int32Max));
                        want.mode         = DRV_VELOCITY;
                        seq_at_min        = 1'b1;
                     end else begin
                        want.mode  = DRV_VELOCITY;
                        want.value = cfg.homing_velocity;
                     end
                  end
                  PH_MOVE: begin
                     want.mode  = DRV_POSITION;
                     want.value = DataWidth'(target);
                     if (near) seq_phase = PH_SETTLE;
                  end
                  default: begin
                     if (near) begin
                        seq_phase  = PH_START;
                        seq_active = 1'b0;
                        seq_gains  = 1'b0;
                        homings_done++;
                     end else begin
                        want.mode  = DRV_POSITION;
                        want.value = DataWidth'(target);
                     end
                  end
               endcase
            end
            want.gains = seq_gains;
            want.phase = seq_phase;
            want.busy  = seq_active;
            commands_due.push_back(want);
         end

         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (commands_due.size() == 0) begin
               mismatches++;
               $display("%0t: result item with no tick outstanding, expected none, got mode %0h",
                        $time, rsp_drive_mode);
            end else begin
               want = commands_due.pop_front();
               check_field("drive_mode", DataWidth'(want.mode), DataWidth'(rsp_drive_mode));
               check_field("drive_value", want.value, rsp_drive_value);
               check_field("rezero", DataWidth'(want.rezero), DataWidth'(rsp_rezero));
               check_field("rezero_value", want.rezero_value, rsp_rezero_value);
               check_field("gains_select", DataWidth'(want.gains), DataWidth'(rsp_gains_select));
               check_field("phase", DataWidth'(want.phase), DataWidth'(rsp_phase));
               check_field("busy_res", DataWidth'(want.busy), DataWidth'(rsp_busy_res));
            end
         end
      end
      outstanding = commands_due.size();
   end

endmodule

FILE: verif/testbench.sv
// Top of the motor homing sequencer testbench: clock, reset, tick and register
// stimulus, verdict. Depends on mhs_pkg, motor_homing_sequencer, homing_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mhs_pkg::*;

   localparam int          CycleLimit  = 300000;
   localparam int          IdleSettle  = 45;
   localparam int          Segments    = 8;
   localparam int          SegmentTicks = 48;
   localparam logic [31:0] WordMin     = 32'h8000_0000;
   localparam logic [31:0] WordMax     = 32'h7FFF_FFFF;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_restart;
   logic                        req_stalled;
   logic signed [DataWidth-1:0] req_measured_position;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [1:0]                  rsp_drive_mode;
   logic signed [DataWidth-1:0] rsp_drive_value;
   logic                        rsp_rezero;
   logic signed [DataWidth-1:0] rsp_rezero_value;
   logic                        rsp_gains_select;
   logic [1:0]                  rsp_phase;
   logic                        rsp_busy_res;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [AddrWidth-1:0]        paddr;
   logic [DataWidth-1:0]        pwdata;
   logic [DataWidth-1:0]        prdata;
   logic                        pready;

   int                          mismatches;
   int                          outstanding;
   int                          results_seen;
   int                          homings_done;
   logic signed [DataWidth-1:0] target_now;

   int     src_idle_pct;
   int     stall_pct;
   int     ticks_sent;
   int     configs_loaded;
   longint tol_now;

   motor_homing_sequencer dut (.*);
   homing_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, outstanding);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [31:0] clamp_word(longint p);
      if (p > longint'($signed(WordMax))) return WordMax;
      if (p < longint'($signed(WordMin))) return WordMin;
      return p[31:0];
   endfunction

   function automatic logic [31:0] small_word();
      logic signed [31:0] v;
      v = $urandom_range(2000);
      return (v - 1000) <<< 12;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return WordMin;
         1: return WordMax;
         2: return '0;
         3, 4: return small_word();
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [TolWidth-1:0] pick_tolerance();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return TolWidth'($urandom());
         default: return TolWidth'($urandom_range(1 << 18, 1));
      endcase
   endfunction

   // Mostly ordered ranges so the sequence can settle; the rest anything goes.
   function automatic cfg_type random_config();
      cfg_type c;
      if ($urandom_range(3) != 0) begin
         c.min_position    = small_word();
         c.max_position    = c.min_position + $urandom_range(1 << 24);
         c.motion_low      = small_word();
         c.motion_high     = c.motion_low + $urandom_range(1 << 24);
         c.motion_start    = c.motion_low + $urandom_range(1 << 25) - (1 << 23);
         c.homing_velocity = small_word();
         c.zero_offset     = small_word();
      end else begin
         c.min_position    = pick_word();
         c.max_position    = pick_word();
         c.motion_low      = pick_word();
         c.motion_high     = pick_word();
         c.motion_start    = pick_word();
         c.homing_velocity = pick_word();
         c.zero_offset     = pick_word();
      end
      c.tolerance = pick_tolerance();
      return c;
   endfunction

   function automatic logic [31:0] near_position();
      longint off;
      if (tol_now == 0) return target_now;
      off = ($urandom_range(3) == 0) ? tol_now - 1 : longint'($urandom_range(tol_now - 1));
      if ($urandom_range(1)) off = -off;
      return clamp_word(longint'(target_now) + off);
   endfunction

   function automatic logic [31:0] far_position();
      if ($urandom_range(2) != 0) return $urandom();
      return clamp_word($urandom_range(1) ? longint'(target_now) + tol_now
                                          : longint'(target_now) - tol_now);
   endfunction

   task automatic send_tick(input bit rst, input bit stl, input logic [31:0] pos);
      int gap;
      gap = 0;
      while ($urandom_range(99) < src_idle_pct) gap++;
      if (gap != 0 && $urandom_range(15) == 0) gap += $urandom_range(40);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid             <= 1'b1;
      req_restart           <= rst;
      req_stalled           <= stl;
      req_measured_position <= pos;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   // Occasionally break the sequence with a restart ahead of the scripted tick.
   task automatic script_tick(input bit stl, input logic [31:0] pos);
      if ($urandom_range(29) == 0) send_tick(1'b1, $urandom_range(1), $urandom());
      send_tick(1'b0, stl, pos);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (IdleSettle) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_config(input cfg_type c);
      wait_idle();
      write_reg(REG_HOMING_VELOCITY, c.homing_velocity);
      write_reg(REG_MIN_POSITION, c.min_position);
      write_reg(REG_MAX_POSITION, c.max_position);
      write_reg(REG_ZERO_OFFSET, c.zero_offset);
      write_reg(REG_MOTION_LOW, c.motion_low);
      write_reg(REG_MOTION_HIGH, c.motion_high);
      write_reg(REG_MOTION_START, c.motion_start);
      write_reg(REG_TOLERANCE, {1'b0, c.tolerance});
      tol_now = c.tolerance;
      configs_loaded++;
   endtask

   task automatic run_homing();
      if ($urandom_range(7) != 0) send_tick(1'b1, $urandom_range(1), $urandom());
      script_tick($urandom_range(1), $urandom());
      repeat ($urandom_range(3)) script_tick(1'b0, $urandom());
      script_tick(1'b1, $urandom());
      script_tick($urandom_range(1), $urandom());
      repeat ($urandom_range(2)) script_tick($urandom_range(1), far_position());
      script_tick($urandom_range(1), near_position());
      repeat ($urandom_range(1)) script_tick($urandom_range(1), far_position());
      script_tick($urandom_range(1), near_position());
      repeat ($urandom_range(2)) send_tick(1'b0, $urandom_range(1), $urandom());
   endtask

   initial begin : stimulus
      cfg_type c;
      int      seg;
      int      segment_end;
      reset                 = 1'b1;
      req_valid             = 1'b0;
      req_restart           = 1'b0;
      req_stalled           = 1'b0;
      req_measured_position = '0;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      src_idle_pct          = 0;
      stall_pct             = 0;
      ticks_sent            = 0;
      configs_loaded        = 0;
      tol_now               = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset registers: zero span, zero tolerance, so the move never settles.
      send_tick(1'b0, 1'b1, WordMin);
      send_tick(1'b0, 1'b0, WordMax);
      send_tick(1'b0, 1'b1, '0);
      send_tick(1'b0, 1'b1, '0);
      send_tick(1'b0, 1'b0, '0);
      send_tick(1'b1, 1'b1, WordMax);

      // Inverted scale and range at the extremes; re-zero saturates high.
      c.homing_velocity = WordMin;
      c.min_position    = WordMax;
      c.max_position    = WordMin;
      c.zero_offset     = WordMax;
      c.motion_low      = WordMax;
      c.motion_high     = WordMin;
      c.motion_start    = WordMax;
      c.tolerance       = '1;
      load_config(c);
      send_tick(1'b0, 1'b0, '0);
      send_tick(1'b0, 1'b0, WordMin);
      send_tick(1'b0, 1'b1, WordMax);
      send_tick(1'b0, 1'b0, '0);
      send_tick(1'b0, 1'b1, WordMin);
      send_tick(1'b0, 1'b0, near_position());
      send_tick(1'b0, 1'b0, near_position());
      send_tick(1'b0, 1'b1, $urandom());

      // Zero motion span, unit tolerance; re-zero saturates low.
      c.homing_velocity = WordMax;
      c.min_position    = WordMin;
      c.max_position    = WordMax;
      c.zero_offset     = WordMin;
      c.motion_low      = 32'd100;
      c.motion_high     = 32'd100;
      c.motion_start    = 32'd5;
      c.tolerance       = TolWidth'(1);
      load_config(c);
      send_tick(1'b1, 1'b0, '0);
      send_tick(1'b0, 1'b0, '0);
      send_tick(1'b0, 1'b1, '0);
      send_tick(1'b0, 1'b0, '0);
      send_tick(1'b0, 1'b0, WordMin + 32'd1);
      send_tick(1'b0, 1'b0, WordMin);
      send_tick(1'b0, 1'b0, WordMax);
      send_tick(1'b0, 1'b0, WordMin);

      for (seg = 0; seg < Segments; seg++) begin
         case (seg % 4)
            0: begin src_idle_pct = 0;  stall_pct = 0;  end
            1: begin src_idle_pct = 54; stall_pct = 0;  end
            2: begin src_idle_pct = 0;  stall_pct = 54; end
            default: begin src_idle_pct = 10; stall_pct = 10; end
         endcase
         load_config(random_config());
         segment_end = ticks_sent + SegmentTicks;
         while (ticks_sent < segment_end) begin
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(4, 1))
                  send_tick($urandom_range(7) == 0, $urandom_range(1), $urandom());
            end else begin
               run_homing();
            end
         end
      end

      wait_idle();
      $display("Drove %0d ticks and checked %0d result items; %0d homing runs reached the target",
               ticks_sent, results_seen, homings_done);
      $display("Used %0d register settings across four handshake idle mixes", configs_loaded + 1);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/mhs_pkg.sv
hw/rtl/mhs_csr.sv
hw/rtl/mhs_muldiv.sv
hw/rtl/mhs_datapath.sv
hw/rtl/mhs_ctrl.sv
hw/rtl/motor_homing_sequencer.sv
verif/homing_checker.sv
verif/testbench.sv
